// ===== sv/bsdp_pkg.sv =====
`default_nettype none
package bsdp_pkg;

    // Reset value of the delimiter register
    localparam logic [7:0] DELIM_RESET = 8'hDE;

    // Register byte offsets
    localparam logic [2:0] ADDR_DELIMITER = 3'd0;

    // End-of-frame status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_START  = 2'd1,
        ST_PARITY = 2'd2,
        ST_ESCAPE = 2'd3
    } t_status;

    // One result as it travels from the front through the queue
    typedef struct packed {
        logic       is_status;
        logic [7:0] data;
        t_status    code;
    } t_result;

    // Front to queue write request
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_wr;

endpackage
`default_nettype wire

// ===== sv/bsdp_front.sv =====
`default_nettype none
module bsdp_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_frame_last,
    input  wire logic [7:0]           i_delimiter,
    output bsdp_pkg::t_result_wr      o_wr
);

    logic               r_at_start, n_at_start;
    logic               r_esc_pend, n_esc_pend;
    logic               r_parity,   n_parity;
    bsdp_pkg::t_status  r_sticky,   n_sticky;

    logic               par_now;
    logic               is_delim;
    bsdp_pkg::t_status  eff_sticky;
    logic               eff_esc;
    bsdp_pkg::t_status  end_code;

    assign par_now  = r_parity ^ (^i_in_byte);
    assign is_delim = (i_in_byte == i_delimiter);

    // Frame state as seen by the final byte
    assign eff_sticky = r_at_start ? (is_delim ? bsdp_pkg::ST_OK : bsdp_pkg::ST_START)
                                   : r_sticky;
    assign eff_esc    = r_at_start ? 1'b0 : r_esc_pend;

    // Rank end-of-frame errors: start, parity, escape
    always_comb begin
        priority if (eff_sticky == bsdp_pkg::ST_START) begin
            end_code = bsdp_pkg::ST_START;
        end else if (par_now) begin
            end_code = bsdp_pkg::ST_PARITY;
        end else if (eff_sticky == bsdp_pkg::ST_ESCAPE || eff_esc) begin
            end_code = bsdp_pkg::ST_ESCAPE;
        end else begin
            end_code = bsdp_pkg::ST_OK;
        end
    end

    // Classify the byte and advance frame state
    always_comb begin
        n_at_start          = r_at_start;
        n_esc_pend          = r_esc_pend;
        n_parity            = r_parity;
        n_sticky            = r_sticky;
        o_wr.valid          = 1'b0;
        o_wr.res.is_status  = 1'b0;
        o_wr.res.data       = i_in_byte;
        o_wr.res.code       = bsdp_pkg::ST_OK;
        if (i_accept) begin
            priority if (i_frame_last) begin
                o_wr.valid         = 1'b1;
                o_wr.res.is_status = 1'b1;
                o_wr.res.data      = 8'd0;
                o_wr.res.code      = end_code;
                n_at_start         = 1'b1;
                n_esc_pend         = 1'b0;
                n_parity           = 1'b0;
                n_sticky           = bsdp_pkg::ST_OK;
            end else if (r_at_start) begin
                n_sticky   = eff_sticky;
                n_esc_pend = 1'b0;
                n_parity   = par_now;
                n_at_start = 1'b0;
            end else begin
                n_parity = par_now;
                if (r_sticky == bsdp_pkg::ST_OK) begin
                    if (r_esc_pend) begin
                        n_esc_pend = 1'b0;
                        if (is_delim) begin
                            o_wr.valid = 1'b1;
                        end else begin
                            n_sticky = bsdp_pkg::ST_ESCAPE;
                        end
                    end else if (is_delim) begin
                        n_esc_pend = 1'b1;
                    end else begin
                        o_wr.valid = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_esc_pend <= 1'b0;
            r_parity   <= 1'b0;
            r_sticky   <= bsdp_pkg::ST_OK;
        end else begin
            r_at_start <= n_at_start;
            r_esc_pend <= n_esc_pend;
            r_parity   <= n_parity;
            r_sticky   <= n_sticky;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bsdp_queue.sv =====
`default_nettype none
module bsdp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire bsdp_pkg::t_result           i_wr_data,
    input  wire logic                        i_rd_en,
    output logic                             o_full,
    output logic                             o_rd_valid,
    output bsdp_pkg::t_result                o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsdp_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count,  n_count;
    logic              do_wr, do_rd;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign o_count    = r_count;

    assign do_wr = i_wr_en && !o_full;
    assign do_rd = i_rd_en && o_rd_valid;

    // Advance pointers with explicit wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bsdp_back.sv =====
`default_nettype none
module bsdp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire bsdp_pkg::t_result  i_q_data,
    output logic                    o_q_rd,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic                    o_is_status,
    output logic [7:0]              o_out_byte,
    output logic [1:0]              o_status_code,
    output logic                    o_result_last
);

    logic              r_valid, n_valid;
    bsdp_pkg::t_result r_res;
    logic              load;

    // Refill the output register when it is free or being drained
    assign load   = i_q_valid && (!r_valid || i_pop);
    assign o_q_rd = load;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_q_data;
        end
    end

    // Format result fields: zero the field that does not apply
    assign o_empty       = !r_valid;
    assign o_is_status   = r_res.is_status;
    assign o_out_byte    = r_res.is_status ? 8'd0 : r_res.data;
    assign o_status_code = r_res.is_status ? r_res.code : bsdp_pkg::ST_OK;
    assign o_result_last = 1'b1;

endmodule
`default_nettype wire

// ===== sv/byte_stuffing_deframer_parity.sv =====
// Byte-stuffing deframer with even parity check. One raw byte is taken per
// clock (push while full is low); a frame opens with the delimiter byte and
// ends with a parity byte marked by frame_last. Doubled delimiters inside the
// frame become one payload byte. Payload bytes come out as they are destuffed,
// and each frame closes with one status transfer (bad start, parity, bad
// escape in that priority, else ok). The front classifies every byte in the
// cycle it is accepted, so the input side sustains one byte per cycle while
// full is low; results leave at one per cycle while pop is held, through a
// QUEUE_DEPTH-entry queue and an output register. A result passes through
// the queue and then the output register before it reaches the output ports,
// and full rises only when QUEUE_DEPTH + 1 results are waiting unpopped.
// The user writes the delimiter register (offset 0x0, reset 0xDE) over the APB
// port only while no frame is in progress; the block does not enforce this.
`default_nettype none
module byte_stuffing_deframer_parity #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_frame_last,
    // result output
    output logic             empty,
    input  wire logic        pop,
    output logic             o_is_status,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status_code,
    output logic             o_result_last,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                   delim_sel;
    logic [7:0]             r_delim;
    logic                   accept;
    logic                   cfg_wr;
    bsdp_pkg::t_result_wr   wr;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_rd;
    bsdp_pkg::t_result      q_data;
    logic [CW-1:0]          q_count;

    // Register access
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign delim_sel = (paddr == bsdp_pkg::ADDR_DELIMITER);
    assign prdata    = delim_sel ? {24'd0, r_delim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= bsdp_pkg::DELIM_RESET;
        end else if (cfg_wr && delim_sel) begin
            r_delim <= pwdata[7:0];
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    bsdp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_frame_last (i_frame_last),
        .i_delimiter  (r_delim),
        .o_wr         (wr)
    );

    bsdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr.valid),
        .i_wr_data  (wr.res),
        .i_rd_en    (q_rd),
        .o_full     (q_full),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_data),
        .o_count    (q_count)
    );

    bsdp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_is_status   (o_is_status),
        .o_out_byte    (o_out_byte),
        .o_status_code (o_status_code),
        .o_result_last (o_result_last)
    );

    // Every final byte closes its frame with a status entry
    a_last_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame_last) |-> (wr.valid && wr.res.is_status))
        else $error("final byte did not produce a status entry");

    // Nothing is produced without an accepted byte
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> !wr.valid)
        else $error("result produced without an input transfer");

    // Payload entries carry no error code
    a_payload_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.valid && !wr.res.is_status) |-> (wr.res.code == bsdp_pkg::ST_OK))
        else $error("payload entry carries a status code");

    // Queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy exceeds depth");

endmodule
`default_nettype wire
